[rtl/core/ati_pkg.sv]
// ----------------------------------------------------------------------------
// ati_pkg
// Shared constants, types and the arctangent table for the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ati_pkg;

  // Fixed-point format of the reduced argument, table entries and the angle
  localparam int FRAC_BITS    = 16;
  localparam int SLOPE_W      = 32;
  localparam int ANGLE_W      = 18;
  localparam int U_W          = FRAC_BITS + 1;   // Q1.16, u <= 1.0
  localparam int Q_W          = 16;              // reciprocal quotient bits
  localparam int P_W          = U_W + 7;         // u * 100
  localparam int IDX_W        = 7;
  localparam int ROM_W        = 16;
  localparam int TABLE_DEPTH  = 102;
  localparam int QUEUE_DEPTH  = 4;
  localparam int NANO_DEN     = 1000000000;
  localparam int unsigned HalfPiNano = 32'd1570796327;
  localparam logic [U_W-1:0] HALF_PI =
    U_W'(((64'(HalfPiNano) << FRAC_BITS) + 64'(NANO_DEN / 2)) / 64'(NANO_DEN));

  typedef logic [ROM_W-1:0] rom_t [0:TABLE_DEPTH-1];
  typedef int unsigned nano_t [0:TABLE_DEPTH-1];

  // atan(k/100) in units of 1e-9
  localparam nano_t ATAN_NANO = '{
    0, 9999666, 19997334, 29991005, 39978687,
    49958397, 59928156, 69885999, 79829983, 89758173,
    99668652, 109559530, 119428930, 129275010, 139095950,
    148889940, 158655260, 168390150, 178092940, 187761950,
    197395560, 206992190, 216550310, 226068390, 235544980,
    244978670, 254368070, 263711840, 273008700, 282257410,
    291456790, 300605680, 309702930, 318747550, 327738490,
    336674810, 345555570, 354379920, 363147020, 371856060,
    380506370, 389097240, 397627980, 406098070, 414506880,
    422853920, 431138750, 439360890, 447519990, 455615640,
    463647600, 471615580, 479519280, 487358570, 495133250,
    502843200, 510488330, 518068550, 525583800, 533034090,
    540419520, 547740040, 554995720, 562186720, 569313170,
    576375250, 583373010, 590306760, 597176670, 603982990,
    610725940, 617405890, 624023080, 630577740, 637070360,
    643501100, 649870460, 656178710, 662426290, 668613550,
    674740970, 680808840, 686817650, 692767860, 698659840,
    704494060, 710271000, 715991140, 721654830, 727262680,
    732815090, 738312600, 743755580, 749144610, 754480180,
    759762760, 764992830, 770170930, 775297520, 780373100,
    785398190, 790373250
  };

  // Round the decimal table to Q0.16 at elaboration
  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      r[k] = ROM_W'(((64'(ATAN_NANO[k]) << FRAC_BITS) + 64'(NANO_DEN / 2))
                    / 64'(NANO_DEN));
    end
    return r;
  endfunction

  localparam rom_t ATAN_ROM = build_rom();

  // Item passed from front to back
  typedef struct packed {
    logic           neg;
    logic           recip;
    logic [U_W-1:0] u;
  } work_t;

endpackage

`default_nettype wire

[rtl/core/arctan_table_interpolator.sv]
// ----------------------------------------------------------------------------
// arctan_table_interpolator
// Arctangent of a signed Q16.16 slope as a signed Q2.16 angle in radians.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one slope per transaction in in_tdata[31:0].
//   Output stream out_*: one angle per transaction in out_tdata[17:0].
//   One result per input, in order. Throughput one transaction per cycle
//   while nothing stalls. The slope enters the first of 17 front stages at
//   acceptance (magnitude plus a 16-stage restoring divider for the
//   reciprocal), then passes through the queue and the four back stages
//   (multiply by 100, table lookup, interpolation multiply, fold and sign).
//   Reset (rst_n low, synchronous) empties all stages and the queue; no
//   table clearing is needed, the arctangent table is constant logic.
//   When the receiver holds out_tready low the back stages hold, the
//   4-entry queue fills, and then the front stages hold and in_tready drops.
//   in_tready does not depend on out_tready combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module arctan_table_interpolator
  import ati_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] slope
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [17:0] angle, [23:18] zero
);

  logic               f_valid, f_ready;
  work_t              f_data;
  logic               b_valid, b_ready;
  work_t              b_data;
  logic [ANGLE_W-1:0] angle;

  ati_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_slope (in_tdata),
    .wk_valid (f_valid),
    .wk_ready (f_ready),
    .wk_data  (f_data)
  );

  ati_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  ati_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wk_valid  (b_valid),
    .wk_ready  (b_ready),
    .wk_data   (b_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_angle (angle)
  );

  assign out_tdata = {6'b0, angle};

endmodule

`default_nettype wire

[rtl/core/ati_front.sv]
// ----------------------------------------------------------------------------
// ati_front
// Takes the slope magnitude, classifies it and forms the reduced argument,
// with a pipelined restoring divider (one quotient bit per stage).
// ----------------------------------------------------------------------------
`default_nettype none

module ati_front
  import ati_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SLOPE_W-1:0] in_slope,
  output logic                    wk_valid,
  input  wire logic               wk_ready,
  output work_t                   wk_data
);

  localparam int NSTG = Q_W + 1;
  localparam int REM_W = SLOPE_W + 1;
  localparam int CMP_W = SLOPE_W + Q_W;

  logic               v_r     [0:NSTG-1];
  logic               neg_r   [0:NSTG-1];
  logic               large_r [0:NSTG-1];
  logic [SLOPE_W-1:0] d_r     [0:NSTG-1];
  logic [REM_W-1:0]   rem_r   [0:NSTG-1];
  logic [Q_W-1:0]     q_r     [0:NSTG-1];
  logic               en;
  logic [SLOPE_W-1:0] mag;

  // Whole pipeline holds while the last stage cannot hand off
  assign en       = !(v_r[NSTG-1] && !wk_ready);
  assign in_ready = en;
  assign mag      = in_slope[SLOPE_W-1] ? (~in_slope + SLOPE_W'(1)) : in_slope;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) v_r[s] <= v_r[s-1];
    end
  end

  // Payload: classify, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]   <= in_slope[SLOPE_W-1];
      large_r[0] <= (mag > SLOPE_W'(1 << FRAC_BITS));
      d_r[0]     <= mag;
      rem_r[0]   <= REM_W'(1) << SLOPE_W;
      q_r[0]     <= '0;
      for (int s = 1; s < NSTG; s++) begin
        logic [CMP_W-1:0] sub;
        logic [CMP_W-1:0] rem_x;
        sub   = CMP_W'(d_r[s-1]) << (Q_W - s);
        rem_x = CMP_W'(rem_r[s-1]);
        neg_r[s]   <= neg_r[s-1];
        large_r[s] <= large_r[s-1];
        d_r[s]     <= d_r[s-1];
        if (rem_x >= sub) begin
          rem_r[s] <= REM_W'(rem_x - sub);
          q_r[s]   <= q_r[s-1] | (Q_W'(1) << (Q_W - s));
        end else begin
          rem_r[s] <= rem_r[s-1];
          q_r[s]   <= q_r[s-1];
        end
      end
    end
  end

  assign wk_valid      = v_r[NSTG-1];
  assign wk_data.neg   = neg_r[NSTG-1];
  assign wk_data.recip = large_r[NSTG-1];
  assign wk_data.u     = large_r[NSTG-1] ? U_W'(q_r[NSTG-1]) : d_r[NSTG-1][U_W-1:0];

endmodule

`default_nettype wire

[rtl/core/ati_fifo.sv]
// ----------------------------------------------------------------------------
// ati_fifo
// Short queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ati_fifo
  import ati_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire work_t wr_data,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output work_t      rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  work_t            mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

[rtl/core/ati_back.sv]
// ----------------------------------------------------------------------------
// ati_back
// Table lookup, linear interpolation, octant fold and sign restore.
// ----------------------------------------------------------------------------
`default_nettype none

module ati_back
  import ati_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wk_valid,
  output logic                    wk_ready,
  input  wire work_t              wk_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ANGLE_W-1:0]      out_angle
);

  logic                   v1_r, v2_r, v3_r, v4_r;
  logic                   en;
  logic                   neg1_r, neg2_r, neg3_r;
  logic                   lg1_r, lg2_r, lg3_r;
  logic [P_W-1:0]         p_r;
  logic [ROM_W-1:0]       lo2_r, lo3_r;
  logic [ROM_W-1:0]       diff_r;
  logic [FRAC_BITS-1:0]   frac_r;
  logic [2*ROM_W-1:0]     prod_r;
  logic [ANGLE_W-1:0]     angle_r;
  logic [IDX_W-1:0]       idx;
  logic [ROM_W-1:0]       lo, hi;
  logic [2*ROM_W-1:0]     rnd;
  logic [U_W-1:0]         t;
  logic [U_W-1:0]         v;

  assign en       = !(v4_r && !out_ready);
  assign wk_ready = en;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= wk_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Table neighbors (index is at most 100)
  assign idx = p_r[FRAC_BITS+IDX_W-1:FRAC_BITS];
  assign lo  = ATAN_ROM[idx];
  assign hi  = ATAN_ROM[idx + IDX_W'(1)];

  // Rounded step and fold
  assign rnd = prod_r + (2*ROM_W)'(1 << (FRAC_BITS - 1));
  assign t   = U_W'(lo3_r) + U_W'(rnd[2*ROM_W-1:FRAC_BITS]);
  assign v   = lg3_r ? (HALF_PI - t) : t;

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= P_W'(wk_data.u) * P_W'(100);
      neg1_r <= wk_data.neg;
      lg1_r  <= wk_data.recip;

      lo2_r  <= lo;
      diff_r <= hi - lo;
      frac_r <= p_r[FRAC_BITS-1:0];
      neg2_r <= neg1_r;
      lg2_r  <= lg1_r;

      prod_r <= (2*ROM_W)'(frac_r) * (2*ROM_W)'(diff_r);
      lo3_r  <= lo2_r;
      neg3_r <= neg2_r;
      lg3_r  <= lg2_r;

      angle_r <= neg3_r ? (~ANGLE_W'(v) + ANGLE_W'(1)) : ANGLE_W'(v);
    end
  end

  assign out_valid = v4_r;
  assign out_angle = angle_r;

endmodule

`default_nettype wire
